@@ rtl/core/ttli_pkg.sv @@
// Shared constants, codes and the sequencer state type for the table time
// linear interpolator. No dependencies.
package ttli_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int WGT_W       = FRAC_BITS + 1;
   localparam int DIV_STEPS   = WGT_W;
   localparam int DCNT_W      = $clog2(DIV_STEPS);

   localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SEARCH,
      ST_DIVIDE,
      ST_VADDR,
      ST_V0,
      ST_V1,
      ST_SUM
   } state_type;

endpackage

@@ rtl/core/ttli_divider.sv @@
// Restoring divider, one quotient bit a cycle, for the blend weight.
// Depends on ttli_pkg.
module ttli_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ttli_pkg::DATA_W-1:0]   num,
   input  logic [ttli_pkg::DATA_W-1:0]   den,
   output logic                          done,
   output logic [ttli_pkg::WGT_W-1:0]    quotient
);
   import ttli_pkg::*;

   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] den_ff;
   logic [WGT_W-1:0]  quo_ff;
   logic              bit_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DATA_W:0]   cand;
   logic              fits;

   // dividend is num << FRAC_BITS; quotient never exceeds one since num <= den
   assign cand = {rem_ff, bit_ff};
   assign fits = cand >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == '0);
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == '0)) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num >> 1;
         bit_ff <= num[0];
         den_ff <= den;
         quo_ff <= '0;
         cnt_ff <= DCNT_W'(DIV_STEPS - 1);
      end else if (run_ff) begin
         rem_ff <= fits ? DATA_W'(cand - {1'b0, den_ff}) : cand[DATA_W-1:0];
         bit_ff <= 1'b0;
         quo_ff <= {quo_ff[WGT_W-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/table_time_linear_interpolator.sv @@
// Table time linear interpolator: time/value table memories, search sequencer,
// shared multiplier and blend. Depends on ttli_pkg and ttli_divider.
// Load word: taken every cycle while not busy, busy stays low, no result.
// Query: empty table gives its result the cycle after start; one entry skips the search,
// a clamped query reads the first and last times, and an interior query searches with
// one time-table read per search step, then runs the 17-step divider.
// Synchronous reset clears control and entry_count; table contents are kept.
module table_time_linear_interpolator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_kind,
   input  logic [ttli_pkg::IDX_W-1:0]         req_entry_index,
   input  logic signed [ttli_pkg::DATA_W-1:0] req_entry_time,
   input  logic signed [ttli_pkg::DATA_W-1:0] req_entry_value,
   input  logic signed [ttli_pkg::DATA_W-1:0] req_query_time,
   output logic                               rsp_strobe,
   output logic signed [ttli_pkg::DATA_W-1:0] rsp_result_value,
   output logic [ttli_pkg::IDX_W-1:0]         rsp_segment_index,
   output logic [ttli_pkg::WGT_W-1:0]         rsp_blend_weight,
   output logic                               rsp_status,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ttli_pkg::CNT_W-1:0]         csr_entry_count
);
   import ttli_pkg::*;

   localparam int PROD_W = DATA_W + WGT_W + 1;

   logic [DATA_W-1:0] time_mem  [TABLE_DEPTH];
   logic [DATA_W-1:0] value_mem [TABLE_DEPTH];

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         n_sat;
   logic [IDX_W-1:0]         last_idx;
   logic                     accept;
   logic                     load_we;

   logic signed [DATA_W-1:0] query_ff, query_in;
   logic signed [DATA_W-1:0] tseg_ff, tseg_in;
   logic [IDX_W-1:0]         seg_ff, seg_in;
   logic [WGT_W-1:0]         wgt_ff, wgt_in;

   logic [IDX_W-1:0]         t_addr, v_addr;
   logic signed [DATA_W-1:0] time_rd_ff, value_rd_ff;

   logic signed [WGT_W:0]    mul_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] p0_ff, p1_ff;
   logic signed [PROD_W:0]   sum;

   logic                     div_start, div_done;
   logic [WGT_W-1:0]         div_quo;
   logic [DATA_W-1:0]        div_num, div_den;
   logic                     stop;

   logic                     strobe_ff, strobe_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic [IDX_W-1:0]         rseg_ff, rseg_in;
   logic [WGT_W-1:0]         rwgt_ff, rwgt_in;
   logic                     rstat_ff, rstat_in;

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign load_we   = accept && (req_kind == KIND_LOAD);

   assign n_sat    = (count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_ff;
   assign last_idx = IDX_W'(n_sat - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         count_ff <= csr_entry_count;
      end
   end

   // table memories, one write and one registered read port each
   always_ff @(posedge clock) begin
      if (load_we) begin
         time_mem[req_entry_index]  <= req_entry_time;
         value_mem[req_entry_index] <= req_entry_value;
      end
      time_rd_ff  <= time_mem[t_addr];
      value_rd_ff <= value_mem[v_addr];
   end

   assign div_num = DATA_W'({query_ff[DATA_W-1], query_ff} - {tseg_ff[DATA_W-1], tseg_ff});
   assign div_den = DATA_W'({time_rd_ff[DATA_W-1], time_rd_ff} - {tseg_ff[DATA_W-1], tseg_ff});
   assign stop    = (seg_ff == IDX_W'(last_idx - 1'b1)) || !(time_rd_ff < query_ff);

   ttli_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // shared multiplier
   assign mul_b = (state_ff == ST_V0) ? $signed({1'b0, ONE - wgt_ff}) : $signed({1'b0, wgt_ff});
   assign prod  = PROD_W'(value_rd_ff * mul_b);
   assign sum   = {p0_ff[PROD_W-1], p0_ff} + {p1_ff[PROD_W-1], p1_ff};

   always_ff @(posedge clock) begin
      if (state_ff == ST_V0) begin
         p0_ff <= prod;
      end
      if (state_ff == ST_V1) begin
         p1_ff <= (wgt_ff == '0) ? '0 : prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff <= query_in;
      tseg_ff  <= tseg_in;
      seg_ff   <= seg_in;
      wgt_ff   <= wgt_in;
      if (strobe_in) begin
         res_ff   <= res_in;
         rseg_ff  <= rseg_in;
         rwgt_ff  <= rwgt_in;
         rstat_ff <= rstat_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      query_in  = query_ff;
      tseg_in   = tseg_ff;
      seg_in    = seg_ff;
      wgt_in    = wgt_ff;
      t_addr    = '0;
      v_addr    = seg_ff;
      div_start = 1'b0;
      strobe_in = 1'b0;
      res_in    = '0;
      rseg_in   = seg_ff;
      rwgt_in   = wgt_ff;
      rstat_in  = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            query_in = req_query_time;
            if (accept && (req_kind == KIND_QUERY)) begin
               if (n_sat == '0) begin
                  strobe_in = 1'b1;
                  rseg_in   = '0;
                  rwgt_in   = '0;
                  rstat_in  = STATUS_EMPTY;
               end else if (n_sat == CNT_W'(1)) begin
                  seg_in   = '0;
                  wgt_in   = '0;
                  state_in = ST_VADDR;
               end else begin
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            tseg_in  = time_rd_ff;
            t_addr   = last_idx;
            state_in = ST_LAST;
         end
         ST_LAST: begin
            t_addr = IDX_W'(1);
            if (query_ff <= tseg_ff) begin
               seg_in   = '0;
               wgt_in   = '0;
               state_in = ST_VADDR;
            end else if (query_ff >= time_rd_ff) begin
               seg_in   = IDX_W'(last_idx - 1'b1);
               wgt_in   = ONE;
               state_in = ST_VADDR;
            end else begin
               seg_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // read of seg+1 arrives now; seg+2 issued ahead
            t_addr = IDX_W'(seg_ff + 2'd2);
            if (stop) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               seg_in  = IDX_W'(seg_ff + 1'b1);
               tseg_in = time_rd_ff;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               wgt_in   = div_quo;
               state_in = ST_VADDR;
            end
         end
         ST_VADDR: begin
            state_in = ST_V0;
         end
         ST_V0: begin
            v_addr   = IDX_W'(seg_ff + 1'b1);
            state_in = ST_V1;
         end
         ST_V1: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            strobe_in = 1'b1;
            res_in    = sum[FRAC_BITS+DATA_W-1:FRAC_BITS];
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_value  = res_ff;
   assign rsp_segment_index = rseg_ff;
   assign rsp_blend_weight  = rwgt_ff;
   assign rsp_status        = rstat_ff;

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_blend_weight <= ONE)
      else $error("blend weight above one");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == STATUS_EMPTY) |->
         (rsp_result_value == '0) && (rsp_blend_weight == '0))
      else $error("empty-table word not zero");

   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      load_we |=> !busy)
      else $error("load left block busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside divide state");

   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == STATUS_OK) |-> $past(state_ff) == ST_SUM)
      else $error("result word without blend");

endmodule
